/* src/tai_pkg.sv */
// Shared types, constants and arithmetic helpers for the three-axis incremental PID block.
`timescale 1ns / 1ps
`default_nettype none

package tai_pkg;

    // Position, error, output and carry width (signed Q16.16 by default).
    localparam int POS_WIDTH = 32;

    // Each gain is unsigned Q8.8. Three gains are packed into one register.
    localparam int GAIN_W = 16;
    localparam int GAINS_W = 3 * GAIN_W;
    localparam int FRAC_SHIFT = 8;

    // Coefficient width: q0 = kp+ki+kd needs 18 bits unsigned, and
    // q1 = -(kp+2kd) needs 19 bits signed.
    localparam int COEF_W = GAIN_W + 3;

    // Full product, product after dropping the gain fraction, and the adder width
    // that holds u + q1*e + q2*last without overflow.
    localparam int PROD_W = POS_WIDTH + COEF_W;
    localparam int SHPROD_W = PROD_W - FRAC_SHIFT;
    localparam int SUM_W = SHPROD_W + 2;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAINS_X = 2'd0,
        REG_GAINS_Y = 2'd1,
        REG_GAINS_Z = 2'd2
    } cfg_reg_t;

    typedef logic signed [POS_WIDTH-1:0] pos_t;

    typedef struct packed {
        pos_t desired_x;
        pos_t desired_y;
        pos_t desired_z;
        pos_t measured_x;
        pos_t measured_y;
        pos_t measured_z;
    } sample_t;

    typedef struct packed {
        pos_t accel_x;
        pos_t accel_y;
        pos_t accel_z;
    } accel_cmd_t;

    // Incremental PID coefficients of one axis.
    typedef struct packed {
        logic signed [COEF_W-1:0] q0;
        logic signed [COEF_W-1:0] q1;
        logic signed [COEF_W-1:0] q2;
    } coef_t;

    // Pipeline advance strobes handed from the control logic to each axis.
    typedef struct packed {
        logic load_err;
        logic load_prod;
        logic load_out;
    } axis_ctrl_t;

    // Clamp a wide signed sum to the signed position range.
    function automatic pos_t sat_pos(input logic signed [SUM_W-1:0] v);
        logic hi_ones;
        logic hi_zeros;
        pos_t result;
        hi_ones = &v[SUM_W-1:POS_WIDTH-1];
        hi_zeros = ~(|v[SUM_W-1:POS_WIDTH-1]);
        if (hi_ones || hi_zeros)
        begin
            result = v[POS_WIDTH-1:0];
        end
        else if (v[SUM_W-1])
        begin
            result = {1'b1, {(POS_WIDTH-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(POS_WIDTH-1){1'b1}}};
        end
        return result;
    endfunction

    // Turn packed kp/ki/kd gains into the incremental form coefficients.
    function automatic coef_t make_coef(input logic [GAINS_W-1:0] gains);
        logic [COEF_W-1:0] kp;
        logic [COEF_W-1:0] ki;
        logic [COEF_W-1:0] kd;
        coef_t c;
        kp = COEF_W'(gains[3*GAIN_W-1:2*GAIN_W]);
        ki = COEF_W'(gains[2*GAIN_W-1:GAIN_W]);
        kd = COEF_W'(gains[GAIN_W-1:0]);
        c.q0 = kp + ki + kd;
        c.q1 = -(kp + (kd << 1));
        c.q2 = kd;
        return c;
    endfunction

endpackage

`default_nettype wire

/* src/three_axis_incremental_pid.sv */
// Top level of the three-axis incremental PID position controller.
// Usage:
//   The sample channel (sample_valid, sample_stall, sample) carries one item of
//   desired and measured x/y/z positions in signed Q16.16. The cmd channel
//   (cmd_valid, cmd_stall, cmd) returns one item of commanded accelerations per
//   sample, in the same order. An item moves on a clock edge where valid is
//   high and stall is low.
//   The cfg channel writes the packed kp/ki/kd gains of one axis per write
//   (index 0 = x, 1 = y, 2 = z); other indexes are ignored. cfg_ready is
//   always high. Gains should only be written while no item is in flight.
// Timing:
//   The edge that accepts a sample loads the error register; later edges load
//   the product and output registers, and cmd_valid rises with the output register.
//   One item per clock is sustained while cmd_stall is low; the carry feedback
//   closes inside the output stage, so consecutive items need no spacing.
// Reset:
//   rst_n clears the gains, the stored previous errors, the carries and all
//   valid flags. No sample is taken until reset is released.
// Back-pressure:
//   When cmd_stall is high the output holds its item. Earlier stages keep
//   filling, so up to three items are held before sample_stall is raised.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_incremental_pid
    import tai_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 sample_valid,
    output logic                      sample_stall,
    input  wire sample_t              sample,
    output logic                      cmd_valid,
    input  wire logic                 cmd_stall,
    output accel_cmd_t                cmd,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [GAINS_W-1:0]   cfg_data
);

    // Valid flags of the three pipeline stages.
    logic err_valid_reg;
    logic err_valid_next;
    logic prod_valid_reg;
    logic prod_valid_next;
    logic out_valid_reg;
    logic out_valid_next;

    // Coefficients are formed once, when the gains are written.
    coef_t coef_x_reg;
    coef_t coef_y_reg;
    coef_t coef_z_reg;

    logic prod_ready;
    logic err_ready;
    axis_ctrl_t ctrl;

    // A stage can take a new item when it is empty or its item moves on
    // in the same cycle.
    assign prod_ready = !prod_valid_reg || !out_valid_reg || !cmd_stall;
    assign err_ready = !err_valid_reg || prod_ready;

    assign ctrl.load_err = sample_valid && err_ready;
    assign ctrl.load_prod = err_valid_reg && prod_ready;
    assign ctrl.load_out = prod_valid_reg && (!out_valid_reg || !cmd_stall);

    always_comb
    begin
        err_valid_next = err_valid_reg;
        if (ctrl.load_err)
        begin
            err_valid_next = 1'b1;
        end
        else if (ctrl.load_prod)
        begin
            err_valid_next = 1'b0;
        end

        prod_valid_next = prod_valid_reg;
        if (ctrl.load_prod)
        begin
            prod_valid_next = 1'b1;
        end
        else if (ctrl.load_out)
        begin
            prod_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!cmd_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            err_valid_reg <= err_valid_next;
            prod_valid_reg <= prod_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Gain registers, stored as incremental coefficients. Writes to an
    // unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_x_reg <= '0;
            coef_y_reg <= '0;
            coef_z_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_GAINS_X: coef_x_reg <= make_coef(cfg_data);
                REG_GAINS_Y: coef_y_reg <= make_coef(cfg_data);
                REG_GAINS_Z: coef_z_reg <= make_coef(cfg_data);
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    tai_axis u_axis_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .coef     (coef_x_reg),
        .desired  (sample.desired_x),
        .measured (sample.measured_x),
        .accel    (cmd.accel_x)
    );

    tai_axis u_axis_y
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .coef     (coef_y_reg),
        .desired  (sample.desired_y),
        .measured (sample.measured_y),
        .accel    (cmd.accel_y)
    );

    tai_axis u_axis_z
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .coef     (coef_z_reg),
        .desired  (sample.desired_z),
        .measured (sample.measured_z),
        .accel    (cmd.accel_z)
    );

    assign sample_stall = !err_ready;
    assign cmd_valid = out_valid_reg;

    // Input is only held off when every stage is full and the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (err_valid_reg && prod_valid_reg && out_valid_reg && cmd_stall))
        else $error("sample stalled while the pipeline has room");

    // An accepted sample always lands in the error stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_valid && !sample_stall) |=> err_valid_reg)
        else $error("accepted sample was lost");

    // A result leaves the output only by being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(cmd_valid) |-> $past(!cmd_stall))
        else $error("result dropped while stalled");

    // An item in the product stage is never overwritten while it cannot move.
    assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid_reg && !ctrl.load_out) |-> !ctrl.load_prod)
        else $error("product stage overwritten");

endmodule

`default_nettype wire

/* src/tai_axis.sv */
// Datapath of one axis: error stage, product stage and output/carry stage.
`timescale 1ns / 1ps
`default_nettype none

module tai_axis
    import tai_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire axis_ctrl_t ctrl,
    input  wire coef_t      coef,
    input  wire pos_t       desired,
    input  wire pos_t       measured,
    output pos_t            accel
);

    pos_t err_reg;
    pos_t last_err_reg;
    pos_t carry_reg;
    pos_t accel_reg;
    logic signed [SHPROD_W-1:0] p0_reg;
    logic signed [SHPROD_W-1:0] p1_reg;
    logic signed [SHPROD_W-1:0] p2_reg;

    logic signed [SUM_W-1:0] err_sum;
    logic signed [PROD_W-1:0] prod0;
    logic signed [PROD_W-1:0] prod1;
    logic signed [PROD_W-1:0] prod2;
    logic signed [SUM_W-1:0] u_sum;
    pos_t u_sat;
    logic signed [SUM_W-1:0] carry_sum;
    pos_t carry_next;

    // Wide error difference, saturated when it is loaded into the error register.
    assign err_sum = SUM_W'(desired) - SUM_W'(measured);

    // Products of the coefficients with the current and previous error.
    assign prod0 = PROD_W'(err_reg) * PROD_W'(coef.q0);
    assign prod1 = PROD_W'(err_reg) * PROD_W'(coef.q1);
    assign prod2 = PROD_W'(last_err_reg) * PROD_W'(coef.q2);

    // Output and next carry; the saturated output feeds the carry.
    assign u_sum = SUM_W'(p0_reg) + SUM_W'(carry_reg);
    assign u_sat = sat_pos(u_sum);
    assign carry_sum = SUM_W'(u_sat) + SUM_W'(p1_reg) + SUM_W'(p2_reg);
    assign carry_next = sat_pos(carry_sum);

    always_ff @(posedge clk)
    begin
        if (ctrl.load_err)
        begin
            err_reg <= sat_pos(err_sum);
        end
        if (ctrl.load_prod)
        begin
            // Dropping the low bits is an arithmetic shift that rounds toward minus infinity.
            p0_reg <= prod0[PROD_W-1:FRAC_SHIFT];
            p1_reg <= prod1[PROD_W-1:FRAC_SHIFT];
            p2_reg <= prod2[PROD_W-1:FRAC_SHIFT];
        end
        if (ctrl.load_out)
        begin
            accel_reg <= u_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_err_reg <= '0;
            carry_reg <= '0;
        end
        else
        begin
            if (ctrl.load_prod)
            begin
                last_err_reg <= err_reg;
            end
            if (ctrl.load_out)
            begin
                carry_reg <= carry_next;
            end
        end
    end

    assign accel = accel_reg;

endmodule

`default_nettype wire

/* tb/accel_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts the accel commands from the observed channels and compares them.
module accel_checker
    import tai_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sample_valid,
    input  logic                 sample_stall,
    input  sample_t              sample,
    input  logic                 cmd_valid,
    input  logic                 cmd_stall,
    input  accel_cmd_t           cmd,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [GAINS_W-1:0]   cfg_data,
    output int                   mismatches,
    output int                   pending
);

    logic [GAINS_W-1:0] gains [3];
    longint last_err [3];
    longint carry [3];
    accel_cmd_t expected_cmds [$];
    int err_total;

    function automatic longint clamp_pos(input longint v);
        longint pos_ceiling;
        pos_ceiling = (longint'(1) <<< (POS_WIDTH - 1)) - 1;
        if (v > pos_ceiling)
        begin
            return pos_ceiling;
        end
        if (v < -pos_ceiling - 1)
        begin
            return -pos_ceiling - 1;
        end
        return v;
    endfunction

    // Gain times error, with the gain fraction dropped toward minus infinity.
    function automatic longint scale_gain(input longint coef, input longint err);
        return (coef * err) >>> FRAC_SHIFT;
    endfunction

    task automatic advance_axis(input int axis, input pos_t desired, input pos_t measured,
                                output pos_t accel);
        longint kp;
        longint ki;
        longint kd;
        longint err;
        longint u;
        kp = longint'(gains[axis][3*GAIN_W-1:2*GAIN_W]);
        ki = longint'(gains[axis][2*GAIN_W-1:GAIN_W]);
        kd = longint'(gains[axis][GAIN_W-1:0]);
        err = clamp_pos(longint'(desired) - longint'(measured));
        u = clamp_pos(scale_gain(kp + ki + kd, err) + carry[axis]);
        carry[axis] = clamp_pos(u + scale_gain(-kp - 2 * kd, err)
                                + scale_gain(kd, last_err[axis]));
        last_err[axis] = err;
        accel = pos_t'(u);
    endtask

    task automatic check_field(input string name, input pos_t want, input pos_t got);
        if (want !== got)
        begin
            err_total++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        accel_cmd_t want;
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                gains[a] = '0;
                last_err[a] = 0;
                carry[a] = 0;
            end
            expected_cmds.delete();
            err_total = 0;
            mismatches <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAINS_X: gains[0] = cfg_data;
                    REG_GAINS_Y: gains[1] = cfg_data;
                    REG_GAINS_Z: gains[2] = cfg_data;
                    default: ;
                endcase
            end
            if (sample_valid && !sample_stall)
            begin
                advance_axis(0, sample.desired_x, sample.measured_x, want.accel_x);
                advance_axis(1, sample.desired_y, sample.measured_y, want.accel_y);
                advance_axis(2, sample.desired_z, sample.measured_z, want.accel_z);
                expected_cmds.push_back(want);
            end
            if (cmd_valid && !cmd_stall)
            begin
                if (expected_cmds.size() == 0)
                begin
                    err_total++;
                    $display("%0t: unexpected command item x=%0d y=%0d z=%0d", $time,
                             cmd.accel_x, cmd.accel_y, cmd.accel_z);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    check_field("accel_x", want.accel_x, cmd.accel_x);
                    check_field("accel_y", want.accel_y, cmd.accel_y);
                    check_field("accel_z", want.accel_z, cmd.accel_z);
                end
            end
            mismatches <= err_total;
            pending <= expected_cmds.size();
        end
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, stimulus, back-pressure and the final verdict.
module tb;
    import tai_pkg::*;

    // Index three decodes to no register; writes to it must leave every gain alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
    localparam pos_t POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam pos_t POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};
    localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
    localparam int PHASES = 12;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    sample_t              sample = '0;
    logic                 cmd_valid;
    logic                 cmd_stall = 1'b0;
    accel_cmd_t           cmd;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [GAINS_W-1:0]   cfg_data = '0;

    int mismatches;
    int pending;

    // Back-pressure control. While recv_quiet is high the receiver starts no new stalled
    // run, and while send_quiet is set the sender offers items back to back.
    logic recv_quiet = 1'b0;
    int   stall_run = 0;
    bit   send_quiet = 1'b0;

    // Slowly moving set points and lagging positions, one per axis. They make
    // the controller see the small, correlated errors of a closed loop.
    pos_t traj_goal [3] = '{default: '0};
    pos_t traj_pos [3] = '{default: '0};

    three_axis_incremental_pid uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    accel_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Length of an idle stretch: mostly none or a few cycles, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 96)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // The receiver alternates between flowing runs and stalled runs of random length.
    always @(posedge clk)
    begin
        if (stall_run != 0)
        begin
            stall_run <= stall_run - 1;
        end
        else if (recv_quiet || $urandom_range(0, 2) != 0)
        begin
            cmd_stall <= 1'b0;
            stall_run <= $urandom_range(0, 6);
        end
        else
        begin
            cmd_stall <= 1'b1;
            stall_run <= idle_len();
        end
    end

    function automatic sample_t pack_sample(input pos_t dx, input pos_t dy, input pos_t dz,
                                            input pos_t mx, input pos_t my, input pos_t mz);
        sample_t s;
        s.desired_x = dx;
        s.desired_y = dy;
        s.desired_z = dz;
        s.measured_x = mx;
        s.measured_y = my;
        s.measured_z = mz;
        return s;
    endfunction

    function automatic pos_t corner_pos();
        case ($urandom_range(0, 5))
            0: return POS_MAX;
            1: return POS_MIN;
            2: return '0;
            3: return -1;
            4: return 1;
            default: return pos_t'($signed($urandom_range(0, 1023)) - 512);
        endcase
    endfunction

    // Most items follow a plausible trajectory; the rest are full-range noise
    // and corner values that drive the error and output clamps.
    function automatic sample_t random_sample();
        pos_t d [3];
        pos_t m [3];
        int style;
        style = $urandom_range(0, 99);
        for (int a = 0; a < 3; a++)
        begin
            if (style < 65)
            begin
                if ($urandom_range(0, 49) == 0)
                begin
                    traj_goal[a] = pos_t'($urandom) >>> $urandom_range(2, 14);
                end
                traj_goal[a] = traj_goal[a] + pos_t'($signed($urandom_range(0, 8192)) - 4096);
                traj_pos[a] = traj_pos[a] + ((traj_goal[a] - traj_pos[a]) >>> 2)
                              + pos_t'($signed($urandom_range(0, 255)) - 128);
                d[a] = traj_goal[a];
                m[a] = traj_pos[a];
            end
            else if (style < 88)
            begin
                d[a] = pos_t'($urandom);
                m[a] = pos_t'($urandom);
            end
            else
            begin
                d[a] = corner_pos();
                m[a] = corner_pos();
            end
        end
        return pack_sample(d[0], d[1], d[2], m[0], m[1], m[2]);
    endfunction

    // Mostly modest gains, with zero, full scale and arbitrary values mixed in.
    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return GAIN_MAX;
            2: return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(0, 16'h0400));
        endcase
    endfunction

    function automatic logic [GAINS_W-1:0] random_gains();
        return {random_gain(), random_gain(), random_gain()};
    endfunction

    // Offer one item and hold it until the block takes it, then maybe leave a gap.
    task automatic send_sample(input sample_t s);
        int gap;
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        gap = send_quiet ? 0 : idle_len();
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering items and wait until every command in flight has come out.
    // The first edge lets the checker count an item taken on the last edge.
    task automatic wait_idle();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // cfg_valid is left high between writes so it never drops and rises in one step.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAINS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic configure(input logic [GAINS_W-1:0] gx, input logic [GAINS_W-1:0] gy,
                             input logic [GAINS_W-1:0] gz, input bit poke_unused);
        wait_idle();
        write_reg(REG_GAINS_X, gx);
        if (poke_unused)
        begin
            write_reg(REG_UNUSED, GAINS_W'({$urandom, $urandom}));
        end
        write_reg(REG_GAINS_Y, gy);
        write_reg(REG_GAINS_Z, gz);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int count;
        logic [GAINS_W-1:0] gx;
        logic [GAINS_W-1:0] gy;
        logic [GAINS_W-1:0] gz;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the gains still at their reset value every command must be zero.
        send_sample(pack_sample(POS_MAX, POS_MIN, 1, POS_MIN, POS_MAX, -1));
        send_sample(random_sample());

        // Full-scale gains on x, a unit proportional gain on y and a half
        // derivative gain on z. A stray write to the unused index sits in between.
        configure({GAINS_W{1'b1}}, {16'h0100, 16'h0000, 16'h0000},
                  {16'h0000, 16'h0000, 16'h0080}, 1'b1);
        // Error overflow in both directions, then output and carry clamps.
        send_sample(pack_sample(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
        send_sample(pack_sample(POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN));
        send_sample(pack_sample(POS_MIN, POS_MIN, POS_MIN, POS_MAX, POS_MAX, POS_MAX));
        send_sample(pack_sample(0, 0, 0, 0, 0, 0));
        send_sample(pack_sample(POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX, POS_MAX));
        // Errors of one LSB exercise rounding of the products toward minus infinity.
        send_sample(pack_sample(-1, -1, -1, 0, 0, 0));
        send_sample(pack_sample(1, 1, 1, 0, 0, 0));
        send_sample(pack_sample(0, 0, 0, 1, 1, 1));
        // Off-by-one overflow of the error subtraction.
        send_sample(pack_sample(POS_MAX, POS_MAX, POS_MAX, -1, -1, -1));
        send_sample(pack_sample(POS_MIN, POS_MIN, POS_MIN, 1, 1, 1));
        send_sample(pack_sample(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0));
        send_sample(pack_sample(POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN));

        // The smallest derivative gain on x, a pure full-scale integrator on y
        // and full proportional plus derivative on z.
        configure({16'h0000, 16'h0000, 16'h0001}, {16'h0000, GAIN_MAX, 16'h0000},
                  {GAIN_MAX, 16'h0000, GAIN_MAX}, 1'b0);
        // A steady error winds the integrator into its clamp, then reverses it.
        repeat (6) send_sample(pack_sample(32'h0040_0000, 32'h0040_0000, 32'h0040_0000,
                                           0, 0, 0));
        send_sample(pack_sample(-3, -255, -256, 0, 0, 0));
        send_sample(pack_sample(-257, -256, -255, 0, 0, 0));
        repeat (3) send_sample(pack_sample(0, 0, 0, 32'h0100_0000, 32'h0100_0000,
                                           32'h0100_0000));

        // Random phases. Each starts from an idle block with a new gain setting;
        // some run the sender back to back, some keep the receiver from stalling.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:
                begin
                    gx = {GAINS_W{1'b1}};
                    gy = {GAINS_W{1'b1}};
                    gz = {GAINS_W{1'b1}};
                end
                1:
                begin
                    gx = '0;
                    gy = '0;
                    gz = '0;
                end
                default:
                begin
                    gx = random_gains();
                    gy = random_gains();
                    gz = random_gains();
                end
            endcase
            configure(gx, gy, gz, 1'($urandom_range(0, 1)));
            send_quiet = (p % 4 == 1);
            recv_quiet <= (p % 4 == 2);
            count = $urandom_range(90, 140);
            for (int i = 0; i < count; i++)
            begin
                send_sample(random_sample());
            end
        end

        wait_idle();
        // Give the pipeline time to show any stray command before the verdict.
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending == 0)
        begin
            $display("[three_axis_incremental_pid] OK");
        end
        else
        begin
            $display("[three_axis_incremental_pid] ERROR");
        end
        $finish;
    end

    // Hard limit on the run, far beyond the slowest correct schedule.
    initial
    begin
        #10_000_000;
        $display("[three_axis_incremental_pid] ERROR");
        $finish;
    end

endmodule

/* three_axis_incremental_pid.f */
src/tai_pkg.sv
src/tai_axis.sv
src/three_axis_incremental_pid.sv
tb/accel_checker.sv
tb/tb.sv
